// ----- rtl/b2d_pkg.sv -----
// Shared constants and types for the binary to decimal ASCII unit.
// No dependencies; every other file uses this package by scoped names.
package b2d_pkg;

  // Widths of the item fields
  localparam int VALUE_W = 20;
  localparam int CHAR_W  = 6;

  // Largest number of digits in one run
  localparam int MAX_DIGITS = 6;

  // Decimal register: one nibble per digit
  localparam int BCD_W = 4 * MAX_DIGITS;

  // Digit counter, holds MAX_DIGITS itself
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // Shift-and-add-3 step counter, one step per input bit
  localparam int STEP_W = $clog2(VALUE_W + 1);

  // ASCII code of '0'
  localparam int ASCII_ZERO = 48;

  // Depth of the queue between front and back (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // 10^n, worked out at elaboration
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Largest value that still fits in MAX_DIGITS decimal digits
  localparam longint unsigned SAT_LIMIT = pow10(MAX_DIGITS) - 1;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/b2d_front.sv -----
// Front end: takes items on the start/busy handshake and clamps them.
// Depends on b2d_pkg; feeds b2d_queue.
module b2d_front (
  input  logic                         start,
  output logic                         busy,
  input  logic [b2d_pkg::VALUE_W-1:0]  value_i,
  input  b2d_pkg::q_stat_t             q_stat_i,
  output logic                         push_o,
  output logic [b2d_pkg::VALUE_W-1:0]  push_data_o
);

  logic over_limit;

  // Busy only while the queue has no free slot
  assign busy   = q_stat_i.full;
  assign push_o = start && !q_stat_i.full;

  // Clamp values that need more digits than the run allows
  assign over_limit = {{(64 - b2d_pkg::VALUE_W){1'b0}}, value_i} > b2d_pkg::SAT_LIMIT;

  always_comb begin
    if (over_limit) begin
      push_data_o = b2d_pkg::VALUE_W'(b2d_pkg::SAT_LIMIT);
    end else begin
      push_data_o = value_i;
    end
  end

endmodule

// ----- rtl/b2d_queue.sv -----
// Short FIFO that decouples the front end from the converter.
// Depends on b2d_pkg.
module b2d_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [b2d_pkg::VALUE_W-1:0]  push_data_i,
  input  logic                         pop_i,
  output logic [b2d_pkg::VALUE_W-1:0]  pop_data_o,
  output b2d_pkg::q_stat_t             q_stat_o
);

  logic [b2d_pkg::VALUE_W-1:0] mem_q [b2d_pkg::QDEPTH];
  logic [b2d_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [b2d_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [b2d_pkg::QCNT_W-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign q_stat_o.empty = (cnt_q == '0);
  assign q_stat_o.full  = (cnt_q == b2d_pkg::QCNT_W'(b2d_pkg::QDEPTH));
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= b2d_pkg::QCNT_W'(b2d_pkg::QDEPTH))
    else $error("queue count overflow");

  // A push on a full queue would lose an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !q_stat_o.full)
    else $error("push into full queue");

  // A pop from an empty queue would invent an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !q_stat_o.empty)
    else $error("pop from empty queue");

endmodule

// ----- rtl/b2d_back.sv -----
// Back end: shift-and-add-3 conversion, then digit emission with
// leading zero suppression. Depends on b2d_pkg; pops from b2d_queue.
module b2d_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  b2d_pkg::q_stat_t             q_stat_i,
  input  logic [b2d_pkg::VALUE_W-1:0]  pop_data_i,
  output logic                         pop_o,
  output logic                         digit_valid_o,
  output logic [b2d_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_digit_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  state_e                      state_q;
  logic [b2d_pkg::VALUE_W-1:0] bin_q;
  logic [b2d_pkg::BCD_W-1:0]   bcd_q, bcd_d;
  logic [b2d_pkg::STEP_W-1:0]  step_q;
  logic [b2d_pkg::CNT_W-1:0]   cnt_q;
  logic                        started_q;
  logic                        strobe_q, last_q;
  logic [b2d_pkg::CHAR_W-1:0]  char_q;
  logic [b2d_pkg::BCD_W-1:0]   adj;
  logic [3:0]                  top_nib;
  logic                        cnt_is_last;

  assign pop_o         = (state_q == S_IDLE) && !q_stat_i.empty;
  assign digit_valid_o = strobe_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;
  assign top_nib       = bcd_q[b2d_pkg::BCD_W-1 -: 4];
  assign cnt_is_last   = (cnt_q == b2d_pkg::CNT_W'(1));

  // One double-dabble step: add 3 to each digit of 5 or more, then shift
  always_comb begin
    for (int i = 0; i < b2d_pkg::MAX_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
    bcd_d = {adj[b2d_pkg::BCD_W-2:0], bin_q[b2d_pkg::VALUE_W-1]};
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      started_q <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      char_q    <= '0;
      bin_q     <= '0;
      bcd_q     <= '0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!q_stat_i.empty) begin
            bin_q   <= pop_data_i;
            bcd_q   <= '0;
            step_q  <= '0;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          bcd_q  <= bcd_d;
          bin_q  <= bin_q << 1;
          step_q <= step_q + 1'b1;
          if (step_q == b2d_pkg::STEP_W'(b2d_pkg::VALUE_W - 1)) begin
            cnt_q     <= b2d_pkg::CNT_W'(b2d_pkg::MAX_DIGITS);
            started_q <= 1'b0;
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Leading zeros are dropped; the units digit always goes out
          if (top_nib != 4'd0 || started_q || cnt_is_last) begin
            strobe_q  <= 1'b1;
            last_q    <= cnt_is_last;
            char_q    <= b2d_pkg::CHAR_W'(b2d_pkg::ASCII_ZERO + int'(top_nib));
            started_q <= 1'b1;
          end
          bcd_q <= bcd_q << 4;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_is_last) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Every emitted character is a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> (char_q >= b2d_pkg::CHAR_W'(48) && char_q <= b2d_pkg::CHAR_W'(57)))
    else $error("non-digit character emitted");

  // The end mark comes only with a strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q)
    else $error("end mark without strobe");

  // Emission of the units digit always closes the run with a mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && cnt_is_last) |=> (strobe_q && last_q && state_q == S_IDLE))
    else $error("run not closed");

endmodule

// ----- rtl/binary_to_decimal_ascii_unit.sv -----
// Binary to decimal ASCII unit. An accepted item waits in the queue, is popped
// in the idle state, converted by 20 shift-and-add-3 steps, one per input bit,
// then swept one digit position at a time with leading zeros dropped. The
// converter takes a new item only once every digit position of the previous one
// is swept; a two-entry queue takes up to two items ahead. The receiver cannot
// stall. Reset is asynchronous, active low.
module binary_to_decimal_ascii_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [b2d_pkg::VALUE_W-1:0]  value_i,
  output logic                         digit_valid_o,
  output logic [b2d_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_digit_o
);

  b2d_pkg::q_stat_t            q_stat;
  logic                        push, pop;
  logic [b2d_pkg::VALUE_W-1:0] push_data, pop_data;

  // Accept and clamp
  b2d_front u_front (
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue
  b2d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  // Convert and emit
  b2d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

endmodule
